// ===== src/cdq_pkg.sv =====
// shared constants for the circular deque: defaults, operation codes, register format
// no dependencies

package cdq_pkg;

  localparam int DEF_MAX_DEPTH  = 1024;
  localparam int DEF_DATA_WIDTH = 16;

  localparam int CFG_W = 11;
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  localparam int FUNC_W = 2;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 2'd3;

endpackage

// ===== src/circular_deque.sv =====
// top level of the circular deque: control, pointers, count and result register
// depends on cdq_pkg and cdq_store

// Bounded double-ended queue in a ring memory. Each operation (insert or remove at
// either end, selected by in_tuser) passes through ST_IDLE, ST_READ and ST_LOAD: the
// accept in ST_IDLE moves a pointer, updates the element count and writes the inserted
// element; ST_READ reads the front and rear entries from the two read ports of the
// store; ST_LOAD loads the result register once it is free. A new operation is
// taken once the result register is loaded; the result may still wait for out_tready.
// The limit written on cfg_wdata caps the element count (values above MAX_DEPTH act as
// MAX_DEPTH, zero refuses every insert); writing it never moves or drops stored
// elements. Empty results show front and rear as zero.

module circular_deque
  import cdq_pkg::*;
#(
  parameter int MAX_DEPTH  = DEF_MAX_DEPTH,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  localparam int IN_TD_W  = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_W    = 2 * DATA_WIDTH + 3,
  localparam int OUT_TD_W = ((OUT_W + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_wdata,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [IN_TD_W-1:0]  in_tdata,   // value
  input  logic [FUNC_W-1:0]   in_tuser,   // func
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_TD_W-1:0] out_tdata   // ok, front_value, rear_value, empty_res, full_res
);

  localparam int AW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CNT_W = $clog2(MAX_DEPTH + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [AW-1:0]    LAST_IDX = AW'(MAX_DEPTH - 1);
  localparam logic [CMP_W-1:0] MAX_LIM  = CMP_W'(MAX_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CFG_W-1:0] depth_in_use_r;
  logic [AW-1:0]    head_r, head_nxt;
  logic [AW-1:0]    tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ok_r, ok_nxt;

  logic                  out_valid_r;
  logic                  res_ok_r, res_empty_r, res_full_r;
  logic [DATA_WIDTH-1:0] res_front_r, res_rear_r;

  logic [AW-1:0]         head_prev, head_next, tail_prev, tail_next;
  logic [CMP_W-1:0]      limit, count_ext;
  logic                  has_room, has_elem, accept, load, now_empty;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] rd_front, rd_rear;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
    ring_next = (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
    ring_prev = (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  assign head_prev = ring_prev(head_r);
  assign head_next = ring_next(head_r);
  assign tail_prev = ring_prev(tail_r);
  assign tail_next = ring_next(tail_r);

  assign limit     = (CMP_W'(depth_in_use_r) > MAX_LIM) ? MAX_LIM : CMP_W'(depth_in_use_r);
  assign count_ext = CMP_W'(count_r);
  assign has_room  = count_ext < limit;
  assign has_elem  = count_r != '0;

  assign in_tready = state_r == ST_IDLE;
  assign accept    = in_tvalid && in_tready;
  assign load      = (state_r == ST_LOAD) && (!out_valid_r || out_tready);
  assign now_empty = count_r == '0;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    ok_nxt    = ok_r;
    wr_en     = 1'b0;
    wr_addr   = tail_r;
    if (accept) begin
      ok_nxt = 1'b0;
      case (in_tuser)
        FUNC_PUSH_FRONT: begin
          if (has_room) begin
            head_nxt  = head_prev;
            wr_en     = 1'b1;
            wr_addr   = head_prev;
            count_nxt = count_r + 1'b1;
            ok_nxt    = 1'b1;
          end
        end
        FUNC_PUSH_BACK: begin
          if (has_room) begin
            tail_nxt  = tail_next;
            wr_en     = 1'b1;
            wr_addr   = tail_r;
            count_nxt = count_r + 1'b1;
            ok_nxt    = 1'b1;
          end
        end
        FUNC_POP_FRONT: begin
          if (has_elem) begin
            head_nxt  = head_next;
            count_nxt = count_r - 1'b1;
            ok_nxt    = 1'b1;
          end
        end
        default: begin
          if (has_elem) begin
            tail_nxt  = tail_prev;
            count_nxt = count_r - 1'b1;
            ok_nxt    = 1'b1;
          end
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_LOAD;
      ST_LOAD: if (load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      depth_in_use_r <= CFG_RESET;
      head_r         <= '0;
      tail_r         <= '0;
      count_r        <= '0;
      ok_r           <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      ok_r    <= ok_nxt;
      if (cfg_we) begin
        depth_in_use_r <= cfg_wdata;
      end
    end
  end

  cdq_store #(
    .MAX_DEPTH  (MAX_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (in_tdata[DATA_WIDTH-1:0]),
    .rd_en     (state_r == ST_READ),
    .rd_addr_a (head_r),
    .rd_addr_b (tail_prev),
    .rd_data_a (rd_front),
    .rd_data_b (rd_rear)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_ok_r    <= ok_r;
      res_front_r <= now_empty ? '0 : rd_front;
      res_rear_r  <= now_empty ? '0 : rd_rear;
      res_empty_r <= now_empty;
      res_full_r  <= !has_room;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TD_W'({res_full_r, res_empty_r, res_rear_r, res_front_r, res_ok_r});

endmodule

// ===== src/cdq_store.sv =====
// ring store of the circular deque: one write port, two registered read ports
// depends on cdq_pkg for default sizes

module cdq_store
  import cdq_pkg::*;
#(
  parameter int MAX_DEPTH  = DEF_MAX_DEPTH,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr_a,
  input  logic [AW-1:0]         rd_addr_b,
  output logic [DATA_WIDTH-1:0] rd_data_a,
  output logic [DATA_WIDTH-1:0] rd_data_b
);

  logic [DATA_WIDTH-1:0] mem [MAX_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ===== src/cdq_checker.sv =====
// port-level checks for the circular deque, bound to the top level
// depends on cdq_pkg and circular_deque

module cdq_checker
  import cdq_pkg::*;
#(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  localparam int OUT_W    = 2 * DATA_WIDTH + 3,
  localparam int OUT_TD_W = ((OUT_W + 7) / 8) * 8
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OUT_TD_W-1:0] out_tdata
);

  localparam int EMPTY_BIT = 2 * DATA_WIDTH + 1;

  logic [DATA_WIDTH-1:0] front_v, rear_v;
  logic                  in_xfer;

  assign front_v = out_tdata[DATA_WIDTH:1];
  assign rear_v  = out_tdata[2*DATA_WIDTH:DATA_WIDTH+1];
  assign in_xfer = in_tvalid && in_tready;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // empty result shows zero peek values
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[EMPTY_BIT] |-> front_v == '0 && rear_v == '0)
    else $error("empty result with nonzero peek values");

  // one operation in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready ##1 !in_tready)
    else $error("input taken while an operation is in flight");

  // no result straight out of reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind circular_deque cdq_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_cdq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// testbench for circular_deque: a scoreboard class mirrors the deque and checks each result
// depends on cdq_pkg and the circular_deque rtl

module testbench;
  import cdq_pkg::*;

  localparam int DEPTH       = DEF_MAX_DEPTH;
  localparam int DW          = DEF_DATA_WIDTH;
  localparam int IN_TD_W     = ((DW + 7) / 8) * 8;
  localparam int OUT_TD_W    = ((2 * DW + 3 + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 27;

  // result fields, lowest bit first: ok, front_value, rear_value, empty_res, full_res
  typedef struct packed {
    logic          full_res;
    logic          empty_res;
    logic [DW-1:0] rear_value;
    logic [DW-1:0] front_value;
    logic          ok;
  } deque_view_t;

  class deque_mirror;
    logic [DW-1:0] ring [DEPTH];
    int unsigned   head;
    int unsigned   tail;
    int unsigned   count;
    int unsigned   limit;
    deque_view_t   pending_views[$];
    int            errors;

    function new();
      head   = 0;
      tail   = 0;
      count  = 0;
      limit  = DEPTH;
      errors = 0;
    endfunction

    function void set_depth(logic [CFG_W-1:0] d);
      limit = (d > DEPTH) ? DEPTH : d;
    endfunction

    function int unsigned prev_slot(int unsigned i);
      return (i == 0) ? DEPTH - 1 : i - 1;
    endfunction

    function int unsigned next_slot(int unsigned i);
      return (i == DEPTH - 1) ? 0 : i + 1;
    endfunction

    function void note_op(logic [FUNC_W-1:0] op, logic [DW-1:0] v);
      deque_view_t r;
      r = '0;
      case (op)
        FUNC_PUSH_FRONT: if (count < limit) begin
          head = prev_slot(head);
          ring[head] = v;
          count++;
          r.ok = 1'b1;
        end
        FUNC_PUSH_BACK: if (count < limit) begin
          ring[tail] = v;
          tail = next_slot(tail);
          count++;
          r.ok = 1'b1;
        end
        FUNC_POP_FRONT: if (count > 0) begin
          head = next_slot(head);
          count--;
          r.ok = 1'b1;
        end
        default: if (count > 0) begin
          tail = prev_slot(tail);
          count--;
          r.ok = 1'b1;
        end
      endcase
      if (count > 0) begin
        r.front_value = ring[head];
        r.rear_value  = ring[prev_slot(tail)];
      end else begin
        r.empty_res = 1'b1;
      end
      r.full_res = (count >= limit);
      pending_views.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_view(logic [OUT_TD_W-1:0] td);
      deque_view_t got;
      deque_view_t want;
      got = td[$bits(deque_view_t)-1:0];
      if (pending_views.size() == 0) begin
        report($sformatf("result %h with nothing expected", td));
      end else begin
        want = pending_views.pop_front();
        if (got.ok != want.ok)
          report($sformatf("ok %b, expected %b", got.ok, want.ok));
        if (got.front_value != want.front_value)
          report($sformatf("front %h, expected %h", got.front_value, want.front_value));
        if (got.rear_value != want.rear_value)
          report($sformatf("rear %h, expected %h", got.rear_value, want.rear_value));
        if (got.empty_res != want.empty_res)
          report($sformatf("empty %b, expected %b", got.empty_res, want.empty_res));
        if (got.full_res != want.full_res)
          report($sformatf("full %b, expected %b", got.full_res, want.full_res));
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_TD_W-1:0]  in_tdata = '0;
  logic [FUNC_W-1:0]   in_tuser = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_TD_W-1:0] out_tdata;

  logic        idle_on = 1'b1;
  logic        hold_off = 1'b0;
  int          items_sent = 0;
  int          cycles = 0;
  deque_mirror mirror = new();

  circular_deque u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      mirror.note_op(in_tuser, in_tdata[DW-1:0]);
    if (rst_n && out_tvalid && out_tready)
      mirror.check_view(out_tdata);
  end

  always @(posedge clk) begin
    out_tready <= !hold_off && (!idle_on || $urandom_range(99) >= IDLE_PCT);
  end

  // long receiver stall while the sender keeps offering
  initial begin
    wait (items_sent >= 600);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (80) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic send_op(input logic [FUNC_W-1:0] op, input logic [DW-1:0] v);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_TD_W'(v);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (mirror.pending_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_depth(input logic [CFG_W-1:0] d);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    mirror.set_depth(d);
  endtask

  function automatic logic [DW-1:0] pick_value();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return DW'($urandom);
    endcase
  endfunction

  task automatic run_random(input int n, input int push_pct);
    logic [FUNC_W-1:0] op;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < push_pct)
        op = $urandom_range(1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
      else
        op = $urandom_range(1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
      send_op(op, pick_value());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty removals, wrap at slot zero, data extremes
    send_op(FUNC_POP_FRONT, 16'h0000);
    send_op(FUNC_POP_BACK, 16'hffff);
    send_op(FUNC_PUSH_BACK, 16'hffff);
    send_op(FUNC_PUSH_FRONT, 16'h0000);
    send_op(FUNC_PUSH_FRONT, 16'h1234);
    send_op(FUNC_POP_BACK, 16'h0000);
    send_op(FUNC_POP_FRONT, 16'h0000);
    send_op(FUNC_POP_FRONT, 16'h0000);
    send_op(FUNC_PUSH_FRONT, 16'haaaa);
    send_op(FUNC_PUSH_BACK, 16'h5555);

    // limit of one, lowered below the count of two
    write_depth(11'd1);
    send_op(FUNC_PUSH_BACK, 16'h0007);
    send_op(FUNC_POP_FRONT, 16'h0000);
    send_op(FUNC_POP_BACK, 16'h0000);
    send_op(FUNC_PUSH_FRONT, 16'h0008);
    send_op(FUNC_PUSH_BACK, 16'h0009);

    // limit of zero refuses every insert
    write_depth(11'd0);
    send_op(FUNC_PUSH_FRONT, 16'hffff);
    send_op(FUNC_POP_BACK, 16'h0000);
    send_op(FUNC_PUSH_BACK, 16'h0001);
    send_op(FUNC_POP_FRONT, 16'h0000);

    // limit above the store size
    write_depth(11'd2047);
    send_op(FUNC_PUSH_BACK, 16'h8001);
    send_op(FUNC_PUSH_FRONT, 16'h7ffe);
    send_op(FUNC_POP_FRONT, 16'h0000);

    write_depth(11'($urandom_range(1, 8)));
    run_random(60, 50);
    write_depth(11'd0);
    run_random(20, 50);

    // fill the whole store and wrap the pointers, part of it with no idling
    write_depth(11'd1024);
    run_random(300, 95);
    idle_on <= 1'b0;
    run_random(400, 95);
    idle_on <= 1'b1;
    run_random(450, 95);
    run_random(100, 20);

    write_depth(11'($urandom_range(2, 40)));
    run_random(60, 55);
    write_depth(11'd2047);
    run_random(60, 90);
    write_depth(11'd3);
    run_random(40, 40);

    drain();
    repeat (6) @(posedge clk);
    if (mirror.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
